// ===== rtl/mbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU reply checker package
// Shared constants, status codes, frame summary type and the CRC-16 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrc_pkg;

  localparam int unsigned DefMaxFrame = 260;
  localparam int unsigned MinFrame    = 5;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PduLenW  = 9;

  localparam logic [CfgIdxW-1:0] CfgSlaveAddr = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPduCap    = 1'b1;

  localparam logic [7:0]         SlaveAddrRst = 8'd1;
  localparam logic [PduLenW-1:0] PduCapRst    = 9'd256;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusShort     = 3'd1,
    StatusBadCrc    = 3'd2,
    StatusWrongAddr = 3'd3,
    StatusTooLong   = 3'd4,
    StatusException = 3'd5
  } mbrc_status_e;

  typedef struct packed {
    logic       crc_ok;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
  } frame_info_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrc_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU reply checker frame tracker
// Holds the running CRC, the byte count and the first three bytes of the frame
// and presents the frame summary that includes the word now being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrc_frame_tracker import mbrc_pkg::*; #(
  parameter int unsigned MaxFrame = DefMaxFrame,
  parameter int unsigned CountW   = $clog2(MaxFrame + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output frame_info_t            info_o,
  output logic      [CountW-1:0] count_o
);

  logic [15:0]       crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        second_q, second_d;
  logic [7:0]        third_q, third_d;

  always_comb begin
    crc_d    = crc_q;
    count_d  = count_q;
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    if (count_q < CountW'(MaxFrame)) begin
      crc_d   = crc16_byte(crc_q, byte_i);
      count_d = count_q + CountW'(1);
      if (count_q == CountW'(0)) begin
        first_d = byte_i;
      end else if (count_q == CountW'(1)) begin
        second_d = byte_i;
      end else if (count_q == CountW'(2)) begin
        third_d = byte_i;
      end
    end
  end

  assign info_o.crc_ok      = (crc_d == 16'h0000);
  assign info_o.first_byte  = first_d;
  assign info_o.second_byte = second_d;
  assign info_o.third_byte  = third_d;
  assign count_o            = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcInit;
      count_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        crc_q    <= CrcInit;
        count_q  <= '0;
        first_q  <= '0;
        second_q <= '0;
        third_q  <= '0;
      end else begin
        crc_q    <= crc_d;
        count_q  <= count_d;
        first_q  <= first_d;
        second_q <= second_d;
        third_q  <= third_d;
      end
    end
  end

`ifndef SYNTH
  // The count saturates at the frame limit.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxFrame))
    else $error("byte count above frame limit");

  // A frame end returns the tracker to its empty state.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> (count_q == '0 && crc_q == CrcInit))
    else $error("frame state not cleared after last word");
`endif

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_reply_checker_core.sv =====
// The registered result appears on the master side in the cycle after the
// last word of a frame is accepted. Throughput: one word per cycle, set by the
// single byte-wide CRC step; a waiting result stalls input only while it is not
// taken. Reset clears the frame state, the result valid and the registers to
// their defaults (slave address 1, PDU capacity 256).
// ----------------------------------------------------------------------------
// Modbus RTU reply checker core
// Checks a received reply frame word by word and reports one status per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_reply_checker_core import mbrc_pkg::*; #(
  parameter int unsigned MaxFrame = DefMaxFrame
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Slave side.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  wire logic                s_axis_tlast,
  // Master side.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata    // [2:0] status, [10:3] function_code,
                                                   // [18:11] exception_code,
                                                   // [27:19] pdu_length, [31:28] zero
);

  localparam int unsigned CountW = $clog2(MaxFrame + 1);
  localparam int unsigned PlenW  = (CountW > PduLenW) ? CountW : PduLenW;

  logic [7:0]         slave_addr_q;
  logic [PduLenW-1:0] pdu_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrRst;
      pdu_cap_q    <= PduCapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlaveAddr: slave_addr_q <= cfg_wdata_i[7:0];
        CfgPduCap:    pdu_cap_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  logic        s_acc;
  logic        out_valid_q;
  frame_info_t info;
  logic [CountW-1:0] count;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  mbrc_frame_tracker #(
    .MaxFrame (MaxFrame),
    .CountW   (CountW)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_acc),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .info_o   (info),
    .count_o  (count)
  );

  logic [PlenW-1:0]   plen;
  logic [PduLenW-1:0] plen_sat;
  mbrc_status_e       status_d;
  logic [7:0]         exc_d;

  always_comb begin
    plen = (count >= CountW'(3)) ? (PlenW'(count) - PlenW'(3)) : '0;
    plen_sat = (plen > PlenW'(511)) ? PduLenW'(511) : plen[PduLenW-1:0];
    exc_d = 8'h00;
    if (count < CountW'(MinFrame)) begin
      status_d = StatusShort;
    end else if (!info.crc_ok) begin
      status_d = StatusBadCrc;
    end else if (info.first_byte != slave_addr_q) begin
      status_d = StatusWrongAddr;
    end else if (plen > PlenW'(pdu_cap_q)) begin
      status_d = StatusTooLong;
    end else if (info.second_byte[7]) begin
      status_d = StatusException;
      exc_d    = info.third_byte;
    end else begin
      status_d = StatusOk;
    end
  end

  mbrc_status_e       status_q;
  logic [7:0]         func_q;
  logic [7:0]         exc_q;
  logic [PduLenW-1:0] plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast) begin
      status_q <= status_d;
      func_q   <= info.second_byte;
      exc_q    <= exc_d;
      plen_q   <= plen_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, plen_q, exc_q, func_q, status_q};

`ifndef SYNTH
  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a pending result");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result after last word");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tlast && (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid)
    else $error("result without a last word");

  a_exc_only_on_exception: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q != StatusException) |-> (exc_q == 8'h00))
    else $error("exception code set without exception status");
`endif

endmodule

`default_nettype wire
